// ===== design/csfs_pkg.sv =====
// Shared types and sizes for the cluster sort-by-first-strip block.
// Used by csfs_ctrl, csfs_dp and cluster_sort_by_first_strip.
package csfs_pkg;

    localparam int MAX_RECORDS  = 64;
    localparam int KEY_BITS     = 10;
    localparam int PAYLOAD_BITS = 32;
    localparam int NUM_BITS     = 6;
    localparam int IDX_BITS     = $clog2(MAX_RECORDS);
    localparam int CNT_BITS     = $clog2(MAX_RECORDS + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,
        S_CMP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic seek_rd;
        logic shift_wr;
        logic place_wr;
        logic emit_rd;
        logic emit_ld;
        logic emit_next;
        logic clear;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic rd_gt;
        logic new_last;
        logic in_last;
        logic out_xfer;
        logic out_last;
    } t_status;

endpackage

// ===== design/csfs_ctrl.sv =====
// Sequencer for the cluster sort: insertion walk, then emission of the set.
// Depends on csfs_pkg; drives the csfs_dp datapath through t_cmd.
module csfs_ctrl
    import csfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_status.full) begin
                        n_state = S_SEEK;
                    end else if (i_status.in_last) begin
                        // dropped record still closes the set
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_SEEK: begin
                if (i_status.pos_zero) begin
                    o_cmd.place_wr = 1'b1;
                    n_state = i_status.new_last ? S_EMIT_RD : S_IDLE;
                end else begin
                    o_cmd.seek_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // move larger keys up one slot; equal keys stay in front
                if (i_status.rd_gt) begin
                    o_cmd.shift_wr = 1'b1;
                    n_state = S_SEEK;
                end else begin
                    o_cmd.place_wr = 1'b1;
                    n_state = i_status.new_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_cmd.emit_ld = 1'b1;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_status.out_xfer) begin
                    if (i_status.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/csfs_dp.sv =====
// Datapath of the cluster sort: record memory, insertion pointer, set flags
// and the output register. Depends on csfs_pkg; commanded by csfs_ctrl.
module csfs_dp
    import csfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [KEY_BITS-1:0]     i_first_strip,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic                    i_last_record,
    input  logic                    i_out_ready,
    output t_status                 o_status,
    output logic                    o_out_valid,
    output logic [NUM_BITS-1:0]     o_cluster_number,
    output logic [KEY_BITS-1:0]     o_sorted_strip,
    output logic [PAYLOAD_BITS-1:0] o_sorted_payload,
    output logic                    o_was_sorted,
    output logic                    o_overflow,
    output logic                    o_last_out
);

    t_rec                  mem [MAX_RECORDS];
    t_rec                  r_rd_data;
    t_rec                  r_new;
    logic                  r_new_last;
    logic [KEY_BITS-1:0]   r_last_key;
    logic [CNT_BITS-1:0]   r_count;
    logic [IDX_BITS-1:0]   r_pos;
    logic [IDX_BITS-1:0]   r_emit_idx;
    logic                  r_order_broken;
    logic                  r_overflow;
    logic                  r_out_valid;
    t_rec                  r_out_rec;
    logic [IDX_BITS-1:0]   r_out_num;
    logic                  r_out_last;

    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    t_rec                  wr_data;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  full;

    assign full = (r_count == CNT_BITS'(MAX_RECORDS));

    always_comb begin
        wr_en   = i_cmd.shift_wr | i_cmd.place_wr;
        wr_addr = r_pos;
        wr_data = i_cmd.shift_wr ? r_rd_data : r_new;
        rd_en   = i_cmd.seek_rd | i_cmd.emit_rd;
        rd_addr = i_cmd.emit_rd ? r_emit_idx : (r_pos - IDX_BITS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new.key  <= i_first_strip;
            r_new.pay  <= i_payload;
            r_new_last <= i_last_record;
            if (!full) begin
                r_last_key <= i_first_strip;
                r_pos      <= r_count[IDX_BITS-1:0];
            end
        end else if (i_cmd.shift_wr) begin
            r_pos <= r_pos - IDX_BITS'(1);
        end
        if (i_cmd.emit_ld) begin
            r_out_rec  <= r_rd_data;
            r_out_num  <= r_emit_idx;
            r_out_last <= ((CNT_BITS'(r_emit_idx) + CNT_BITS'(1)) == r_count);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_order_broken <= 1'b0;
            r_overflow     <= 1'b0;
            r_emit_idx     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (full) begin
                    r_overflow <= 1'b1;
                end else if ((r_count != '0) && (r_last_key > i_first_strip)) begin
                    r_order_broken <= 1'b1;
                end
            end
            if (i_cmd.place_wr) begin
                r_count <= r_count + CNT_BITS'(1);
            end
            if (i_cmd.emit_ld) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit_next) begin
                r_emit_idx <= r_emit_idx + IDX_BITS'(1);
            end
            // set delivered: start over
            if (i_cmd.clear) begin
                r_count        <= '0;
                r_order_broken <= 1'b0;
                r_overflow     <= 1'b0;
                r_emit_idx     <= '0;
            end
        end
    end

    always_comb begin
        o_status.full     = full;
        o_status.pos_zero = (r_pos == '0);
        o_status.rd_gt    = (r_rd_data.key > r_new.key);
        o_status.new_last = r_new_last;
        o_status.in_last  = i_last_record;
        o_status.out_xfer = r_out_valid & i_out_ready;
        o_status.out_last = r_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_cluster_number = NUM_BITS'(r_out_num);
    assign o_sorted_strip   = r_out_rec.key;
    assign o_sorted_payload = r_out_rec.pay;
    assign o_was_sorted     = ~r_order_broken;
    assign o_overflow       = r_overflow;
    assign o_last_out       = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_RECORDS))
        else $error("record count above capacity");

    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |-> (r_pos != '0))
        else $error("shift below slot zero");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_ld |-> (CNT_BITS'(r_emit_idx) < r_count))
        else $error("emission index beyond stored records");

    a_place_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place_wr |-> !full)
        else $error("record placed into a full store");

endmodule

// ===== design/cluster_sort_by_first_strip.sv =====
// Cluster records enter one per transfer and are kept sorted by first strip
// as they arrive, by a stable insertion walk through a single-port-pair record
// memory of MAX_RECORDS entries: each stored record of greater key is read
// and then written one slot up, and the new record is written into the slot
// left free. A record that arrives when the store is full is dropped and flags
// overflow. The record marked last closes the set, also when it is dropped:
// after its insertion the block emits every stored record in key order, equal
// keys in arrival order, numbered from 0, with was_sorted, overflow and
// last_out; each result waits until the consumer has taken the one before.
// No input is taken while a set is being emitted. Depends on csfs_pkg,
// csfs_ctrl and csfs_dp.
module cluster_sort_by_first_strip
    import csfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [KEY_BITS-1:0]     i_first_strip,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic                    i_last_record,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [NUM_BITS-1:0]     o_cluster_number,
    output logic [KEY_BITS-1:0]     o_sorted_strip,
    output logic [PAYLOAD_BITS-1:0] o_sorted_payload,
    output logic                    o_was_sorted,
    output logic                    o_overflow,
    output logic                    o_last_out
);

    t_cmd    cmd;
    t_status status;

    csfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    csfs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_first_strip    (i_first_strip),
        .i_payload        (i_payload),
        .i_last_record    (i_last_record),
        .i_out_ready      (i_out_ready),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_cluster_number (o_cluster_number),
        .o_sorted_strip   (o_sorted_strip),
        .o_sorted_payload (o_sorted_payload),
        .o_was_sorted     (o_was_sorted),
        .o_overflow       (o_overflow),
        .o_last_out       (o_last_out)
    );

endmodule

// ===== tb/cluster_sort_by_first_strip_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for cluster_sort_by_first_strip: directed and random cluster sets,
// scored against a stable-sort predictor held in a small scoreboard class.
// Depends on csfs_pkg and the cluster_sort_by_first_strip RTL.
module cluster_sort_by_first_strip_tb;
    import csfs_pkg::*;

    typedef struct packed {
        logic [NUM_BITS-1:0]     number;
        logic [KEY_BITS-1:0]     strip;
        logic [PAYLOAD_BITS-1:0] pay;
        logic                    sorted;
        logic                    ovf;
        logic                    last_out;
    } t_cluster_out;

    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_RISING,
        KEYS_FALLING
    } t_key_shape;

    class cluster_scoreboard;
        logic [KEY_BITS-1:0]     held_key[MAX_RECORDS];
        logic [PAYLOAD_BITS-1:0] held_pay[MAX_RECORDS];
        logic [KEY_BITS-1:0]     prev_key;
        int unsigned             n_held;
        bit                      out_of_order;
        bit                      dropped_any;
        t_cluster_out            awaited[$];
        int unsigned             n_bad;

        function new();
            n_held       = 0;
            out_of_order = 0;
            dropped_any  = 0;
            n_bad        = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Keep the held records in key order; equal keys stay behind earlier arrivals.
        function void note_record(logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] pay,
                                  logic last);
            int unsigned  pos;
            int unsigned  i;
            t_cluster_out r;
            if (n_held < MAX_RECORDS) begin
                if (n_held > 0 && prev_key > key)
                    out_of_order = 1;
                pos = n_held;
                while (pos > 0 && held_key[pos-1] > key) begin
                    held_key[pos] = held_key[pos-1];
                    held_pay[pos] = held_pay[pos-1];
                    pos--;
                end
                held_key[pos] = key;
                held_pay[pos] = pay;
                prev_key      = key;
                n_held++;
            end else begin
                dropped_any = 1;
            end
            if (last) begin
                for (i = 0; i < n_held; i++) begin
                    r.number   = i[NUM_BITS-1:0];
                    r.strip    = held_key[i];
                    r.pay      = held_pay[i];
                    r.sorted   = !out_of_order;
                    r.ovf      = dropped_any;
                    r.last_out = (i + 1 == n_held);
                    awaited.push_back(r);
                end
                n_held       = 0;
                out_of_order = 0;
                dropped_any  = 0;
            end
        endfunction

        function void check_result(t_cluster_out got);
            t_cluster_out want;
            if (awaited.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: number %0d strip %0d payload %h",
                             got.number, got.strip, got.pay);
            end else begin
                want = awaited.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("mismatch: number exp %0d got %0d, strip exp %0d got %0d",
                                 want.number, got.number, want.strip, got.strip);
                        $display("  payload exp %h got %h, was_sorted exp %b got %b",
                                 want.pay, got.pay, want.sorted, got.sorted);
                        $display("  overflow exp %b got %b, last_out exp %b got %b",
                                 want.ovf, got.ovf, want.last_out, got.last_out);
                    end
                end
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [KEY_BITS-1:0]     i_first_strip;
    logic [PAYLOAD_BITS-1:0] i_payload;
    logic                    i_last_record;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [NUM_BITS-1:0]     o_cluster_number;
    logic [KEY_BITS-1:0]     o_sorted_strip;
    logic [PAYLOAD_BITS-1:0] o_sorted_payload;
    logic                    o_was_sorted;
    logic                    o_overflow;
    logic                    o_last_out;

    cluster_scoreboard sb;
    int unsigned       idle_pct = 31;
    int unsigned       n_sent   = 0;

    cluster_sort_by_first_strip i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_first_strip    (i_first_strip),
        .i_payload        (i_payload),
        .i_last_record    (i_last_record),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cluster_number (o_cluster_number),
        .o_sorted_strip   (o_sorted_strip),
        .o_sorted_payload (o_sorted_payload),
        .o_was_sorted     (o_was_sorted),
        .o_overflow       (o_overflow),
        .o_last_out       (o_last_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Score each output transfer and pick the next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_cluster_number, o_sorted_strip, o_sorted_payload,
                              o_was_sorted, o_overflow, o_last_out});
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_record(input logic [KEY_BITS-1:0] key,
                               input logic [PAYLOAD_BITS-1:0] pay, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_first_strip <= key;
        i_payload     <= pay;
        i_last_record <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_record(key, pay, last);
        n_sent++;
    endtask

    task automatic send_cluster_set(input int unsigned n_rec, input t_key_shape shape);
        int unsigned k;
        int          level;
        int          base;
        int          step;
        base  = $urandom_range(0, 1023);
        level = base;
        for (k = 0; k < n_rec; k++) begin
            step = $urandom_range(0, 2);
            case (shape)
                KEYS_WIDE:    level = $urandom_range(0, 1023);
                KEYS_NARROW:  level = (base & 1020) + $urandom_range(0, 3);
                KEYS_RISING: begin
                    level = level + step;
                    if (level > 1023)
                        level = 1023;
                end
                default: begin
                    level = level - step;
                    if (level < 0)
                        level = 0;
                end
            endcase
            send_record(level[KEY_BITS-1:0], $urandom(), k == n_rec - 1);
        end
    endtask

    // Hold the input side until every sorted record is out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_small_set();
        int unsigned n_rec;
        n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_cluster_set(n_rec, t_key_shape'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0)
            drain_results();
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_first_strip <= '0;
        i_payload     <= '0;
        i_last_record <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-record sets at both extremes.
        send_record(10'd0, 32'h0000_0000, 1'b1);
        send_record(10'd1023, 32'hffff_ffff, 1'b1);
        // Equal keys must come out in arrival order.
        send_record(10'd5, 32'h0000_000a, 1'b0);
        send_record(10'd5, 32'h0000_000b, 1'b0);
        send_record(10'd3, 32'h0000_000c, 1'b0);
        send_record(10'd5, 32'h0000_000d, 1'b0);
        send_record(10'd1023, 32'h0000_000e, 1'b0);
        send_record(10'd0, 32'h0000_000f, 1'b1);
        // Already in order, with repeats.
        send_record(10'd0, 32'h5555_5555, 1'b0);
        send_record(10'd0, 32'haaaa_aaaa, 1'b0);
        send_record(10'd7, 32'h8000_0001, 1'b0);
        send_record(10'd1023, 32'h7fff_fffe, 1'b1);
        drain_results();
        // Fully reversed.
        send_record(10'd1023, 32'haaaa_aaaa, 1'b0);
        send_record(10'd512, 32'h5555_5555, 1'b0);
        send_record(10'd1, 32'hffff_0000, 1'b0);
        send_record(10'd0, 32'h0000_ffff, 1'b1);

        while (n_sent < 20)
            send_small_set();

        // Stretch without idling: small sets, then a store filled exactly.
        idle_pct = 0;
        repeat (2) send_small_set();
        send_cluster_set(MAX_RECORDS, KEYS_WIDE);
        idle_pct = 31;

        // Overrun the store; the marked record itself is dropped.
        send_cluster_set(MAX_RECORDS + $urandom_range(1, 4), t_key_shape'($urandom_range(0, 3)));
        drain_results();

        while (n_sent < 170)
            send_small_set();

        drain_results();
        repeat (100) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
design/csfs_pkg.sv
design/csfs_ctrl.sv
design/csfs_dp.sv
design/cluster_sort_by_first_strip.sv
tb/cluster_sort_by_first_strip_tb.sv
